[hw/rtl/scs_pkg.sv]
// Shared types, codes and constants of the SATA DMA command splitter.
package scs_pkg;

  localparam int MAX_ENTRIES_DEF      = 8;
  localparam int ENTRY_BYTES_LOG2_DEF = 22;
  localparam int SLOTS_DEF            = 32;

  localparam int LBA_W      = 48;
  localparam int SECT_W     = 32;
  localparam int ADDR_W     = 64;
  localparam int BUSY_W     = 32;
  localparam int SLOT_W     = 5;
  localparam int OPCODE_W   = 8;
  localparam int COUNT_W    = 16;
  localparam int ENTS_W     = 4;
  localparam int EBM1_W     = 22;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;

  // Chunk holds up to 65536 sectors; byte count covers 16 entries of 4 MiB.
  localparam int CHUNK_W    = 17;
  localparam int BYTES_W    = 27;
  localparam int JOB_ENTS_W = 5;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK = 17'h10000;

  localparam int SHIFT_MIN = 9;
  localparam int SHIFT_MAX = 12;

  localparam logic [3:0] SHIFT_RESET = 4'd9;
  localparam logic [5:0] SLOT_COUNT_RESET = 6'd32;
  localparam logic DEVICE_PRESENT_RESET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_PRESENT = 2'd2;

  localparam logic ACT_REQUEST    = 1'b0;
  localparam logic ACT_COMPLETION = 1'b1;

  localparam logic [1:0] CC_OK      = 2'd0;
  localparam logic [1:0] CC_TIMEOUT = 2'd2;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 8'h35;
  localparam logic [OPCODE_W-1:0] OP_READ  = 8'h25;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_STATUS = 2'd2
  } item_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_DEVICE = 3'd1,
    ST_BUSY      = 3'd2,
    ST_ERROR     = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_t;

  typedef enum logic {
    FS_IDLE,
    FS_ISSUE
  } front_state_t;

  // One unit of work for the back end: a status beat or a whole command.
  typedef struct packed {
    logic                  is_cmd;
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic                  write;
    logic [LBA_W-1:0]      lba;
    logic [CHUNK_W-1:0]    chunk;
    logic [JOB_ENTS_W-1:0] ents;
    logic [ADDR_W-1:0]     addr;
    logic [BYTES_W-1:0]    bytes;
  } job_t;

endpackage

[hw/rtl/scs_if.sv]
// Valid/ready channel interfaces for requests and result beats.
interface scs_in_if;
  import scs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [LBA_W-1:0]     start_lba;
  logic [SECT_W-1:0]    sector_total;
  logic [ADDR_W-1:0]    buffer_addr;
  logic                 is_write;
  logic [BUSY_W-1:0]    busy_slots;
  logic [1:0]           completion_code;

  modport source (
    output valid, action, start_lba, sector_total, buffer_addr, is_write,
           busy_slots, completion_code,
    input  ready
  );
  modport sink (
    input  valid, action, start_lba, sector_total, buffer_addr, is_write,
           busy_slots, completion_code,
    output ready
  );
endinterface

interface scs_out_if;
  import scs_pkg::*;
  logic                 valid;
  logic                 ready;
  item_kind_t           item_kind;
  logic [SLOT_W-1:0]    slot;
  logic [OPCODE_W-1:0]  opcode;
  logic [LBA_W-1:0]     cmd_lba;
  logic [COUNT_W-1:0]   count_field;
  logic [ENTS_W-1:0]    entry_total;
  logic                 write_flag;
  logic [ADDR_W-1:0]    entry_addr;
  logic [EBM1_W-1:0]    entry_bytes_m1;
  status_t              status;
  logic                 last;

  modport source (
    output valid, item_kind, slot, opcode, cmd_lba, count_field, entry_total,
           write_flag, entry_addr, entry_bytes_m1, status, last,
    input  ready
  );
  modport sink (
    input  valid, item_kind, slot, opcode, cmd_lba, count_field, entry_total,
           write_flag, entry_addr, entry_bytes_m1, status, last,
    output ready
  );
endinterface

[hw/rtl/scs_front.sv]
// Front end: config registers, request/completion decode, command sizing.
module scs_front #(
  parameter int MAX_ENTRIES      = scs_pkg::MAX_ENTRIES_DEF,
  parameter int ENTRY_BYTES_LOG2 = scs_pkg::ENTRY_BYTES_LOG2_DEF,
  parameter int SLOTS            = scs_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  scs_in_if.sink                           in_ch,
  input  logic                             cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output scs_pkg::job_t                    q_job
);
  import scs_pkg::*;

  localparam int MAXBYTES = MAX_ENTRIES << ENTRY_BYTES_LOG2;
  localparam int EBYTES   = 1 << ENTRY_BYTES_LOG2;

  logic [1:0] shift_off;
  logic [5:0] slot_count;
  logic       device_present;

  front_state_t          state, state_next;
  logic [SECT_W-1:0]     remaining, remaining_next;
  logic [LBA_W-1:0]      cur_lba, cur_lba_next;
  logic [ADDR_W-1:0]     cur_addr, cur_addr_next;
  logic                  dir_write, dir_write_next;
  logic                  in_progress, in_progress_next;
  logic [CHUNK_W-1:0]    issued, issued_next;
  logic [SLOTS-1:0]      busy_q, busy_q_next;

  logic                  accept;
  logic [3:0]            shift;
  logic [5:0]            slot_lim;
  logic [SLOTS-1:0]      free;
  logic                  found;
  logic [SLOT_W-1:0]     free_slot;
  logic [BYTES_W-1:0]    mchunk;
  logic [CHUNK_W-1:0]    chunk_raw, chunk;
  logic [BYTES_W-1:0]    bytes;
  logic [BYTES_W:0]      ents_sum;
  logic [JOB_ENTS_W-1:0] ents;

  // Sector shift is stored as its offset from 512-byte sectors, already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_off      <= 2'(SHIFT_RESET - 4'(SHIFT_MIN));
      slot_count     <= SLOT_COUNT_RESET;
      device_present <= DEVICE_PRESENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECTOR_SHIFT: begin
          if (cfg_data[3:0] < 4'(SHIFT_MIN)) begin
            shift_off <= 2'd0;
          end else if (cfg_data[3:0] > 4'(SHIFT_MAX)) begin
            shift_off <= 2'(SHIFT_MAX - SHIFT_MIN);
          end else begin
            shift_off <= 2'(cfg_data[3:0] - 4'(SHIFT_MIN));
          end
        end
        CFG_SLOT_COUNT:     slot_count     <= cfg_data;
        CFG_DEVICE_PRESENT: device_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign shift        = 4'(SHIFT_MIN) + 4'(shift_off);
  assign in_ch.ready  = (state == FS_IDLE) && !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  // Lowest free slot below the implemented count
  assign slot_lim = (slot_count > 6'(SLOTS)) ? 6'(SLOTS) : slot_count;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free[i] = !busy_q[i] && (6'(i) < slot_lim);
    end
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
    found = |free;
  end

  // Command size: 64K sectors, then the scatter list capacity
  always_comb begin
    mchunk    = BYTES_W'(MAXBYTES) >> shift;
    chunk_raw = (remaining > SECT_W'(MAX_CHUNK)) ? MAX_CHUNK : remaining[CHUNK_W-1:0];
    chunk     = (BYTES_W'(chunk_raw) > mchunk) ? mchunk[CHUNK_W-1:0] : chunk_raw;
    bytes     = BYTES_W'(chunk) << shift;
    ents_sum  = (BYTES_W+1)'(bytes) + (BYTES_W+1)'(EBYTES - 1);
    ents      = JOB_ENTS_W'(ents_sum >> ENTRY_BYTES_LOG2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FS_IDLE;
      remaining   <= '0;
      cur_lba     <= '0;
      cur_addr    <= '0;
      dir_write   <= 1'b0;
      in_progress <= 1'b0;
      issued      <= '0;
      busy_q      <= '0;
    end else begin
      state       <= state_next;
      remaining   <= remaining_next;
      cur_lba     <= cur_lba_next;
      cur_addr    <= cur_addr_next;
      dir_write   <= dir_write_next;
      in_progress <= in_progress_next;
      issued      <= issued_next;
      busy_q      <= busy_q_next;
    end
  end

  always_comb begin
    state_next       = state;
    remaining_next   = remaining;
    cur_lba_next     = cur_lba;
    cur_addr_next    = cur_addr;
    dir_write_next   = dir_write;
    in_progress_next = in_progress;
    issued_next      = issued;
    busy_q_next      = busy_q;
    q_push           = 1'b0;
    q_job            = '0;
    q_job.status     = ST_OK;

    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          if (in_ch.action == ACT_REQUEST) begin
            priority if (in_progress) begin
              q_push       = 1'b1;
              q_job.status = ST_BUSY;
            end else if (!device_present) begin
              q_push       = 1'b1;
              q_job.status = ST_NO_DEVICE;
            end else if (in_ch.sector_total == '0) begin
              q_push       = 1'b1;
              q_job.status = ST_OK;
            end else begin
              remaining_next = in_ch.sector_total;
              cur_lba_next   = in_ch.start_lba;
              cur_addr_next  = in_ch.buffer_addr;
              dir_write_next = in_ch.is_write;
              busy_q_next    = in_ch.busy_slots[SLOTS-1:0];
              state_next     = FS_ISSUE;
            end
          end else if (in_progress) begin
            if (in_ch.completion_code != CC_OK) begin
              in_progress_next = 1'b0;
              remaining_next   = '0;
              issued_next      = '0;
              q_push           = 1'b1;
              q_job.status     = (in_ch.completion_code == CC_TIMEOUT) ? ST_TIMEOUT
                                                                       : ST_ERROR;
            end else begin
              remaining_next = remaining - SECT_W'(issued);
              cur_lba_next   = cur_lba + LBA_W'(issued);
              cur_addr_next  = cur_addr + (ADDR_W'(issued) << shift);
              issued_next    = '0;
              busy_q_next    = in_ch.busy_slots[SLOTS-1:0];
              state_next     = FS_ISSUE;
            end
          end
        end
      end
      FS_ISSUE: begin
        if (!q_full) begin
          state_next = FS_IDLE;
          q_push     = 1'b1;
          priority if (remaining == '0) begin
            in_progress_next = 1'b0;
            q_job.status     = ST_OK;
          end else if (!found) begin
            in_progress_next = 1'b0;
            remaining_next   = '0;
            issued_next      = '0;
            q_job.status     = ST_BUSY;
          end else begin
            in_progress_next = 1'b1;
            issued_next      = chunk;
            q_job.is_cmd     = 1'b1;
            q_job.slot       = free_slot;
            q_job.write      = dir_write;
            q_job.lba        = cur_lba;
            q_job.chunk      = chunk;
            q_job.ents       = ents;
            q_job.addr       = cur_addr;
            q_job.bytes      = bytes;
          end
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

endmodule

[hw/rtl/scs_job_queue.sv]
// Two-entry queue of jobs between the front and back ends.
module scs_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scs_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output scs_pkg::job_t head,
  output logic          empty
);
  import scs_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

endmodule

[hw/rtl/scs_back.sv]
// Back end: expands a job into header, scatter entry or status beats.
module scs_back #(
  parameter int ENTRY_BYTES_LOG2 = scs_pkg::ENTRY_BYTES_LOG2_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  scs_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  scs_out_if.source     out_ch
);
  import scs_pkg::*;

  localparam int EBYTES = 1 << ENTRY_BYTES_LOG2;

  logic [JOB_ENTS_W-1:0] idx;
  logic                  emit;
  logic                  job_done;
  logic [JOB_ENTS_W-1:0] ent_num;
  logic [BYTES_W-1:0]    bytes_m1;

  logic                  out_valid;
  item_kind_t            kind_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [OPCODE_W-1:0]   opcode_r;
  logic [LBA_W-1:0]      lba_r;
  logic [COUNT_W-1:0]    count_r;
  logic [ENTS_W-1:0]     ents_r;
  logic                  wflag_r;
  logic [ADDR_W-1:0]     eaddr_r;
  logic [EBM1_W-1:0]     ebm1_r;
  status_t               status_r;
  logic                  last_r;

  assign emit     = !q_empty && (!out_valid || out_ch.ready);
  assign job_done = !head.is_cmd || (idx == head.ents);
  assign q_pop    = emit && job_done;
  assign ent_num  = idx - JOB_ENTS_W'(1);
  assign bytes_m1 = head.bytes - BYTES_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= job_done ? '0 : idx + JOB_ENTS_W'(1);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slot_r   <= '0;
      opcode_r <= '0;
      lba_r    <= '0;
      count_r  <= '0;
      ents_r   <= '0;
      wflag_r  <= 1'b0;
      eaddr_r  <= '0;
      ebm1_r   <= '0;
      status_r <= ST_OK;
      last_r   <= job_done;
      if (!head.is_cmd) begin
        kind_r   <= KIND_STATUS;
        status_r <= head.status;
      end else if (idx == '0) begin
        kind_r   <= KIND_HEADER;
        slot_r   <= head.slot;
        opcode_r <= head.write ? OP_WRITE : OP_READ;
        lba_r    <= head.lba;
        count_r  <= head.chunk[COUNT_W-1:0];
        ents_r   <= head.ents[ENTS_W-1:0];
        wflag_r  <= head.write;
      end else begin
        kind_r  <= KIND_ENTRY;
        slot_r  <= head.slot;
        eaddr_r <= head.addr + (ADDR_W'(ent_num) << ENTRY_BYTES_LOG2);
        // last entry carries the remainder, the others a full entry
        ebm1_r  <= job_done ? EBM1_W'(bytes_m1[ENTRY_BYTES_LOG2-1:0])
                            : EBM1_W'(EBYTES - 1);
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.item_kind      = kind_r;
  assign out_ch.slot           = slot_r;
  assign out_ch.opcode         = opcode_r;
  assign out_ch.cmd_lba        = lba_r;
  assign out_ch.count_field    = count_r;
  assign out_ch.entry_total    = ents_r;
  assign out_ch.write_flag     = wflag_r;
  assign out_ch.entry_addr     = eaddr_r;
  assign out_ch.entry_bytes_m1 = ebm1_r;
  assign out_ch.status         = status_r;
  assign out_ch.last           = last_r;

endmodule

[hw/rtl/sata_dma_command_splitter_unit.sv]
// Top level of the SATA DMA command splitter.
// Requests and completion reports enter on in_ch; header, scatter entry and
// status beats leave on out_ch, last marking the final beat of each input.
// A refused request or a failed completion is taken in FS_IDLE, and its status
// beat passes through the job queue and the back-end output register to out_ch;
// an ignored completion is taken and yields no beat. A new request or an ok
// completion also passes through FS_ISSUE for sizing and slot search, with in_ch
// not ready, and its first beat (a header, or a status beat when the transfer
// ends or no slot is free) then takes the same path through queue and register.
// The back end sends one beat per cycle while out_ch is ready: the header and up
// to MAX_ENTRIES entries. A two-job queue lets the front take the next input
// while the back still streams, as long as out_ch drains.
module sata_dma_command_splitter_unit #(
  parameter int MAX_ENTRIES      = scs_pkg::MAX_ENTRIES_DEF,
  parameter int ENTRY_BYTES_LOG2 = scs_pkg::ENTRY_BYTES_LOG2_DEF,
  parameter int SLOTS            = scs_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  scs_in_if.sink                         in_ch,
  scs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scs_pkg::*;

  logic q_push;
  job_t q_push_job;
  logic q_full;
  logic q_pop;
  job_t q_head;
  logic q_empty;

  scs_front #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .ENTRY_BYTES_LOG2 (ENTRY_BYTES_LOG2),
    .SLOTS            (SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_push_job)
  );

  scs_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  scs_back #(
    .ENTRY_BYTES_LOG2 (ENTRY_BYTES_LOG2)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.item_kind == KIND_STATUS) |-> out_ch.last)
    else $error("status beat without last");

  a_header_not_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.item_kind == KIND_HEADER) |-> !out_ch.last)
    else $error("header beat marked last");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the SATA DMA command splitter unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scs_pkg::*;

  localparam int          SETTLE_CYCLES = 20;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [1:0]  CC_TASK_FILE  = 2'd1;
  localparam logic [1:0]  CC_RESERVED   = 2'd3;
  localparam longint      ENTRY_BYTES   = longint'(1) << ENTRY_BYTES_LOG2_DEF;
  localparam longint      CMD_BYTES_MAX = MAX_ENTRIES_DEF * ENTRY_BYTES;
  localparam longint      SECTORS_MAX   = 65536;

  typedef struct packed {
    logic              action;
    logic [LBA_W-1:0]  lba;
    logic [SECT_W-1:0] sectors;
    logic [ADDR_W-1:0] addr;
    logic              wr;
    logic [BUSY_W-1:0] busy;
    logic [1:0]        code;
  } request_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [SLOT_W-1:0]   slot;
    logic [OPCODE_W-1:0] opcode;
    logic [LBA_W-1:0]    lba;
    logic [COUNT_W-1:0]  count;
    logic [ENTS_W-1:0]   ents;
    logic                wflag;
    logic [ADDR_W-1:0]   addr;
    logic [EBM1_W-1:0]   bytes_m1;
    status_t             status;
    logic                last;
  } beat_t;

  class command_scoreboard;
    beat_t             pending_beats[$];
    int                fails;
    int                beats_checked;
    int                commands_built;
    logic [3:0]        sector_shift;
    logic [5:0]        slot_count;
    logic              device_present;
    logic [SECT_W-1:0] sectors_left;
    logic [LBA_W-1:0]  cur_lba;
    logic [ADDR_W-1:0] cur_addr;
    logic              dir_write;
    logic              busy_req;
    logic [CHUNK_W-1:0] outstanding;

    function new();
      sector_shift   = SHIFT_RESET;
      slot_count     = SLOT_COUNT_RESET;
      device_present = DEVICE_PRESENT_RESET;
      sectors_left   = '0;
      cur_lba        = '0;
      cur_addr       = '0;
      dir_write      = 1'b0;
      busy_req       = 1'b0;
      outstanding    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SECTOR_SHIFT:   sector_shift = val[3:0];
        CFG_SLOT_COUNT:     slot_count = val;
        CFG_DEVICE_PRESENT: device_present = val[0];
        default: ;
      endcase
    endfunction

    function int eff_shift();
      if (sector_shift < SHIFT_MIN) return SHIFT_MIN;
      if (sector_shift > SHIFT_MAX) return SHIFT_MAX;
      return int'(sector_shift);
    endfunction

    function void push_status(status_t st);
      beat_t b;
      b = '0;
      b.kind = KIND_STATUS;
      b.status = st;
      b.last = 1'b1;
      pending_beats.push_back(b);
    endfunction

    function void abort_request(status_t st);
      busy_req = 1'b0;
      sectors_left = '0;
      outstanding = '0;
      push_status(st);
    endfunction

    function void build_command(logic [BUSY_W-1:0] busy);
      int          lim;
      int          sl;
      int          shift;
      bit          found;
      longint      chunk;
      longint      nbytes;
      longint      left;
      longint      e;
      logic [ADDR_W-1:0] off;
      beat_t       b;
      beat_t       cmd[$];
      lim = (slot_count > SLOTS_DEF) ? SLOTS_DEF : int'(slot_count);
      found = 0;
      sl = 0;
      for (int s = 0; s < lim; s++) begin
        if (!busy[s]) begin
          found = 1;
          sl = s;
          break;
        end
      end
      if (!found) begin
        abort_request(ST_BUSY);
        return;
      end
      shift = eff_shift();
      chunk = (sectors_left > SECTORS_MAX) ? SECTORS_MAX : longint'(sectors_left);
      nbytes = chunk << shift;
      if (nbytes > CMD_BYTES_MAX) begin
        chunk = CMD_BYTES_MAX >> shift;
        nbytes = chunk << shift;
      end
      b = '0;
      b.kind = KIND_HEADER;
      b.slot = SLOT_W'(sl);
      b.opcode = dir_write ? OP_WRITE : OP_READ;
      b.lba = cur_lba;
      b.count = chunk[15:0];
      b.ents = ENTS_W'((nbytes + ENTRY_BYTES - 1) >> ENTRY_BYTES_LOG2_DEF);
      b.wflag = dir_write;
      cmd.push_back(b);
      left = nbytes;
      off = '0;
      while (left > 0 && cmd.size() <= MAX_ENTRIES_DEF) begin
        e = (left > ENTRY_BYTES) ? ENTRY_BYTES : left;
        b = '0;
        b.kind = KIND_ENTRY;
        b.slot = SLOT_W'(sl);
        b.addr = cur_addr + off;
        b.bytes_m1 = EBM1_W'(e - 1);
        cmd.push_back(b);
        off += e;
        left -= e;
      end
      cmd[cmd.size()-1].last = 1'b1;
      foreach (cmd[i]) pending_beats.push_back(cmd[i]);
      outstanding = chunk[CHUNK_W-1:0];
      busy_req = 1'b1;
      commands_built++;
    endfunction

    // Returns the number of result beats this input causes.
    function int note_input(request_t it);
      int before_cnt;
      before_cnt = pending_beats.size();
      if (it.action == ACT_REQUEST) begin
        if (busy_req) push_status(ST_BUSY);
        else if (!device_present) push_status(ST_NO_DEVICE);
        else if (it.sectors == 0) push_status(ST_OK);
        else begin
          cur_lba = it.lba;
          sectors_left = it.sectors;
          cur_addr = it.addr;
          dir_write = it.wr;
          build_command(it.busy);
        end
      end else if (busy_req) begin
        if (it.code != CC_OK) begin
          abort_request((it.code == CC_TIMEOUT) ? ST_TIMEOUT : ST_ERROR);
        end else begin
          sectors_left -= SECT_W'(outstanding);
          cur_lba += LBA_W'(outstanding);
          cur_addr += ADDR_W'(outstanding) << eff_shift();
          outstanding = '0;
          if (sectors_left == 0) begin
            busy_req = 1'b0;
            push_status(ST_OK);
          end else begin
            build_command(it.busy);
          end
        end
      end
      return pending_beats.size() - before_cnt;
    endfunction

    function void match(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
        fails++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t exp_b;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: kind %0d status %0d", got.kind, got.status);
        fails++;
        return;
      end
      exp_b = pending_beats.pop_front();
      match("item_kind", 64'(exp_b.kind), 64'(got.kind));
      match("slot", 64'(exp_b.slot), 64'(got.slot));
      match("opcode", 64'(exp_b.opcode), 64'(got.opcode));
      match("cmd_lba", 64'(exp_b.lba), 64'(got.lba));
      match("count_field", 64'(exp_b.count), 64'(got.count));
      match("entry_total", 64'(exp_b.ents), 64'(got.ents));
      match("write_flag", 64'(exp_b.wflag), 64'(got.wflag));
      match("entry_addr", exp_b.addr, got.addr);
      match("entry_bytes_m1", 64'(exp_b.bytes_m1), 64'(got.bytes_m1));
      match("status", 64'(exp_b.status), 64'(got.status));
      match("last", 64'(exp_b.last), 64'(got.last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    gaps_on;
  int                    hold_cycles;
  int                    settings_run;
  int                    inputs_sent;
  int                    quiet_cycles;
  beat_t                 got_beat;
  command_scoreboard     sb = new();

  scs_in_if  in_ch();
  scs_out_if out_ch();

  sata_dma_command_splitter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10ns clk = ~clk;

  function automatic logic [SECT_W-1:0] rand_sectors();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 45) return $urandom_range(1, 64);
    if (r < 70) return $urandom_range(65, 140000);
    if (r < 85) begin
      case ($urandom_range(0, 7))
        0: return 32'd65535;
        1: return 32'd65536;
        2: return 32'd65537;
        3: return 32'd8191;
        4: return 32'd8192;
        5: return 32'd8193;
        6: return 32'd16384;
        default: return 32'd131072;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [BUSY_W-1:0] rand_busy();
    int unsigned r;
    logic [63:0] low_mask;
    r = $urandom_range(0, 99);
    low_mask = (64'd1 << $urandom_range(0, 32)) - 64'd1;
    if (r < 45) return low_mask[BUSY_W-1:0];
    if (r < 70) return $urandom;
    if (r < 78) return '1;
    return '0;
  endfunction

  function automatic request_t rand_fields();
    request_t it;
    it.action  = 1'($urandom_range(0, 1));
    it.lba     = LBA_W'({$urandom, $urandom});
    it.sectors = $urandom;
    it.addr    = {$urandom, $urandom};
    it.wr      = 1'($urandom_range(0, 1));
    it.busy    = $urandom;
    it.code    = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic request_t mk_req(logic [LBA_W-1:0] lba, logic [SECT_W-1:0] n,
                                      logic [ADDR_W-1:0] addr, logic wr,
                                      logic [BUSY_W-1:0] busy);
    request_t it;
    it = rand_fields();
    it.action = ACT_REQUEST;
    it.lba = lba;
    it.sectors = n;
    it.addr = addr;
    it.wr = wr;
    it.busy = busy;
    return it;
  endfunction

  function automatic request_t mk_cpl(logic [1:0] code, logic [BUSY_W-1:0] busy);
    request_t it;
    it = rand_fields();
    it.action = ACT_COMPLETION;
    it.code = code;
    it.busy = busy;
    return it;
  endfunction

  task automatic push_item(input request_t it, output int produced);
    if (gaps_on && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= it.action;
    in_ch.start_lba       <= it.lba;
    in_ch.sector_total    <= it.sectors;
    in_ch.buffer_addr     <= it.addr;
    in_ch.is_write        <= it.wr;
    in_ch.busy_slots      <= it.busy;
    in_ch.completion_code <= it.code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    produced = sb.note_input(it);
    inputs_sent++;
  endtask

  // Abort any open request, then let the block drain completely.
  task automatic quiesce();
    int n;
    if (sb.busy_req) push_item(mk_cpl(CC_TIMEOUT, rand_busy()), n);
    in_ch.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [3:0] shift, logic [5:0] slots, logic present);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SECTOR_SHIFT;
    cfg_data  <= CFG_DATA_W'(shift);
    sb.write_reg(CFG_SECTOR_SHIFT, CFG_DATA_W'(shift));
    @(posedge clk);
    cfg_index <= CFG_SLOT_COUNT;
    cfg_data  <= slots;
    sb.write_reg(CFG_SLOT_COUNT, slots);
    @(posedge clk);
    cfg_index <= CFG_DEVICE_PRESENT;
    cfg_data  <= CFG_DATA_W'(present);
    sb.write_reg(CFG_DEVICE_PRESENT, CFG_DATA_W'(present));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly complete transfers with random content, plus refused and stray inputs.
  task automatic run_random(int target);
    int       done;
    int       cmds;
    int       n;
    request_t it;
    done = 0;
    cmds = 0;
    while (done < target) begin
      if (sb.busy_req) begin
        if ($urandom_range(0, 99) < 6) begin
          it = mk_req(LBA_W'({$urandom, $urandom}), rand_sectors(), {$urandom, $urandom},
                      1'($urandom_range(0, 1)), rand_busy());
        end else begin
          it = mk_cpl(CC_OK, rand_busy());
          case ($urandom_range(0, 99))
            0, 1, 2, 3:   it.code = CC_TASK_FILE;
            4, 5, 6:      it.code = CC_TIMEOUT;
            7, 8:         it.code = CC_RESERVED;
            default:      it.code = CC_OK;
          endcase
          if (cmds > 30) it.code = CC_TASK_FILE;
          cmds++;
        end
      end else begin
        cmds = 0;
        if ($urandom_range(0, 99) < 12) it = mk_cpl(2'($urandom_range(0, 3)), $urandom);
        else it = mk_req(LBA_W'({$urandom, $urandom}), rand_sectors(),
                         {$urandom, $urandom}, 1'($urandom_range(0, 1)), rand_busy());
      end
      push_item(it, n);
      if (n > 0) done++;
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_ch.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 99) < 10) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got_beat.kind     = out_ch.item_kind;
      got_beat.slot     = out_ch.slot;
      got_beat.opcode   = out_ch.opcode;
      got_beat.lba      = out_ch.cmd_lba;
      got_beat.count    = out_ch.count_field;
      got_beat.ents     = out_ch.entry_total;
      got_beat.wflag    = out_ch.write_flag;
      got_beat.addr     = out_ch.entry_addr;
      got_beat.bytes_m1 = out_ch.entry_bytes_m1;
      got_beat.status   = out_ch.status;
      got_beat.last     = out_ch.last;
      sb.check_beat(got_beat);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d beats outstanding", sb.pending_beats.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_REQUEST;
    in_ch.start_lba       <= '0;
    in_ch.sector_total    <= '0;
    in_ch.buffer_addr     <= '0;
    in_ch.is_write        <= 1'b0;
    in_ch.busy_slots      <= '0;
    in_ch.completion_code <= CC_OK;
    gaps_on = 1'b1;
    hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    configure(SHIFT_RESET, SLOT_COUNT_RESET, 1'b1);
    push_item(mk_cpl(CC_OK, '0), n);
    push_item(mk_req('1, 32'd0, '1, 1'b1, '0), n);
    push_item(mk_req('1, 32'd1, '1, 1'b1, '0), n);
    push_item(mk_cpl(CC_OK, '0), n);
    push_item(mk_req(48'hFFFF_FFFF_FFF0, 32'd65537, 64'hFFFF_FFFF_FF00_0000, 1'b0,
                     32'h7FFF_FFFF), n);
    push_item(mk_req('0, 32'd5, '0, 1'b1, '0), n);
    push_item(mk_cpl(CC_OK, 32'hFFFF_FFFE), n);
    push_item(mk_cpl(CC_OK, '0), n);
    push_item(mk_req('0, 32'd100, '0, 1'b0, '1), n);
    push_item(mk_req(48'h1234_5678_9ABC, 32'd131072, 64'h8000_0000_0000_0000, 1'b1,
                     32'h0000_FFFF), n);
    push_item(mk_cpl(CC_TASK_FILE, '0), n);
    push_item(mk_req('0, 32'd500, 64'h0000_0000_0040_0000, 1'b0, '0), n);
    push_item(mk_cpl(CC_TIMEOUT, '0), n);
    push_item(mk_req('0, 32'd500, '0, 1'b1, '0), n);
    push_item(mk_cpl(CC_RESERVED, '0), n);
    push_item(mk_req('0, 32'hFFFF_FFFF, '0, 1'b1, 32'h5555_5555), n);
    push_item(mk_cpl(CC_OK, 32'hAAAA_AAAA), n);
    push_item(mk_cpl(CC_OK, 32'h7FFF_FFFF), n);
    push_item(mk_cpl(CC_TIMEOUT, '0), n);
    push_item(mk_req(48'h0000_0001_0000, 32'd65540, '0, 1'b0, '0), n);
    push_item(mk_cpl(CC_OK, '1), n);
    push_item(mk_cpl(CC_OK, '0), n);
    quiesce();

    run_random(90);
    quiesce();
    configure(4'd12, 6'd40, 1'b1);
    hold_cycles = HOLD_CYCLES;
    run_random(90);
    quiesce();
    configure(4'd0, 6'd1, 1'b1);
    run_random(80);
    quiesce();
    configure(4'd15, 6'd0, 1'b1);
    run_random(20);
    quiesce();
    configure(4'd10, 6'd63, 1'b0);
    run_random(20);
    quiesce();
    configure(4'd11, 6'd7, 1'b1);
    run_random(90);
    quiesce();
    gaps_on = 1'b0;
    configure(SHIFT_RESET, SLOT_COUNT_RESET, 1'b1);
    run_random(90);
    quiesce();

    $display("Ran %0d inputs over %0d register settings: %0d commands built, %0d beats checked",
             inputs_sent, settings_run, sb.commands_built, sb.beats_checked);
    if (sb.fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
hw/rtl/scs_pkg.sv
hw/rtl/scs_if.sv
hw/rtl/scs_front.sv
hw/rtl/scs_job_queue.sv
hw/rtl/scs_back.sv
hw/rtl/sata_dma_command_splitter_unit.sv
tb/testbench.sv
